// ----- design/rbc_pkg.sv -----
`timescale 1ns / 1ps
package rbc_pkg;

   localparam int MAX_ELEMS = 64;
   localparam int IDX_W     = $clog2(MAX_ELEMS);
   localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
   // One bank bit on top of the element index: two sets live in the store.
   localparam int ADDR_W    = IDX_W + 1;
   localparam int DEPTH     = 2 * (2 ** IDX_W);
   localparam int VALUE_W   = 32;
   localparam int RANK_W    = 7;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last_item;
   } req_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              last_rank;
      logic              dropped;
   } rsp_type;

   // One complete set handed from the loader to the ranker.
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             dropped;
      logic             bank;
   } job_type;

   // Ranker tells the loader that a bank may be reused.
   typedef struct packed {
      logic valid;
      logic bank;
   } free_type;

endpackage

// ----- design/rbc_ram.sv -----
`timescale 1ns / 1ps
module rbc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/rbc_queue.sv -----
`timescale 1ns / 1ps
module rbc_queue import rbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign full       = (fill_ff == 2'd2);
   assign head_valid = (fill_ff != 2'd0);
   assign head_job   = slot_ff[rptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wptr_in = wptr_ff ^ do_push;
      rptr_in = rptr_ff ^ do_pop;
      fill_in = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

endmodule

// ----- design/rbc_front.sv -----
`timescale 1ns / 1ps
module rbc_front import rbc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   output logic               wr_en,
   output logic [ADDR_W-1:0]  wr_addr,
   output logic [VALUE_W-1:0] wr_data,
   output logic               q_push,
   output job_type            q_job,
   input  logic               q_full,
   input  free_type           free
);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             bank_ff, bank_in;
   logic [1:0]       busy_ff, busy_in;
   logic             accept;
   logic             room;

   // Hold input while the bank being filled still waits for ranking.
   assign req_stall = busy_ff[bank_ff] | q_full;
   assign accept    = req_valid & ~req_stall;
   assign room      = (count_ff < CNT_W'(MAX_ELEMS));

   assign wr_en   = accept & room;
   assign wr_addr = {bank_ff, count_ff[IDX_W-1:0]};
   assign wr_data = req_data.value;

   assign q_push        = accept & req_data.last_item;
   assign q_job.count   = room ? (count_ff + CNT_W'(1)) : count_ff;
   assign q_job.dropped = ovf_ff | ~room;
   assign q_job.bank    = bank_ff;

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      bank_in  = bank_ff;
      busy_in  = busy_ff;
      if (free.valid) begin
         busy_in[free.bank] = 1'b0;
      end
      if (accept) begin
         if (req_data.last_item) begin
            count_in         = '0;
            ovf_in           = 1'b0;
            bank_in          = ~bank_ff;
            busy_in[bank_ff] = 1'b1;
         end else if (room) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         bank_ff  <= 1'b0;
         busy_ff  <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

// ----- design/rbc_back.sv -----
`timescale 1ns / 1ps
module rbc_back import rbc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  job_type            q_job,
   output logic               q_pop,
   output logic [ADDR_W-1:0]  rd_addr,
   input  logic [VALUE_W-1:0] rd_data,
   output free_type           free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_KEY  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]         state_ff, state_in;
   job_type            job_ff, job_in;
   logic [IDX_W-1:0]   i_ff, i_in;
   logic [CNT_W-1:0]   j_ff, j_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]   less_ff, less_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               smaller;
   logic               is_last;

   assign smaller = ($signed(rd_data) < $signed(key_ff));
   assign is_last = ((CNT_W'(i_ff) + CNT_W'(1)) == job_ff.count);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      key_in       = key_ff;
      less_in      = less_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      free         = '0;
      rd_addr      = {job_ff.bank, i_ff};
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               job_in  = q_job;
               i_in    = '0;
               rd_addr = {q_job.bank, IDX_W'(0)};
               if (q_job.count == '0) begin
                  free = '{valid: 1'b1, bank: q_job.bank};
               end else begin
                  state_in = ST_KEY;
               end
            end
         end
         ST_KEY: begin
            key_in   = rd_data;
            rd_addr  = {job_ff.bank, IDX_W'(0)};
            j_in     = CNT_W'(1);
            less_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            less_in = less_ff + CNT_W'(smaller);
            if (j_ff == job_ff.count) begin
               state_in = ST_EMIT;
            end else begin
               rd_addr = {job_ff.bank, j_ff[IDX_W-1:0]};
               j_in    = j_ff + CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_in.rank      = RANK_W'(less_ff) + RANK_W'(1);
               rsp_in.last_rank = is_last;
               rsp_in.dropped   = job_ff.dropped;
               if (is_last) begin
                  free     = '{valid: 1'b1, bank: job_ff.bank};
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  rd_addr  = {job_ff.bank, i_ff + IDX_W'(1)};
                  state_in = ST_KEY;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      key_ff  <= key_in;
      less_ff <= less_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/rank_by_counting.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake           Transaction
// req      in         req_valid/req_stall one value, last_item closes the set
// rsp      out        rsp_valid/rsp_stall one rank per stored value, load order
//
// Flow: the loader takes a new value whenever req_stall is low; each rank then
//   fetches its key, compares it with all n stored values (n the set size) and emits,
//   since one RAM read port walks every stored value per rank; taking a set off the queue is its own step.
// The store has two banks, so the next set loads while the previous one ranks.
// Reset: synchronous; no clearing pass, only entries of the current set are read.
// Stalls: rsp_stall holds the ranker; req_stall rises only when both banks wait.
module rank_by_counting import rbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic               q_push;
   job_type            q_job;
   logic               q_full;
   logic               q_pop;
   logic               q_valid;
   job_type            q_head;
   free_type           free;

   // Loader: store values, count, and hand finished sets to the queue.
   rbc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .q_push    (q_push),
      .q_job     (q_job),
      .q_full    (q_full),
      .free      (free)
   );

   // Two-bank value store: one write port for the loader, one read for the ranker.
   rbc_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Short job queue decoupling the loader from the ranker.
   rbc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (q_head)
   );

   // Ranker: one compare per cycle, result held in the output register.
   rbc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_job     (q_head),
      .q_pop     (q_pop),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A finished set must always find room in the queue.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("job queue overflow");

   // A rank never exceeds the capacity and is never zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.rank != '0) && (rsp_data.rank <= RANK_W'(MAX_ELEMS)))
      else $error("rank out of range");

   // A bank is never released in the same cycle it is handed over.
   assert property (@(posedge clock) disable iff (reset)
      (free.valid && q_push) |-> (free.bank != q_job.bank))
      else $error("bank released while being queued");

endmodule
